>>> src/spd_pkg.sv
`timescale 1ns / 1ps

package spd_pkg;

    // Operation codes carried by the mode field.
    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_LOOKUP = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_UPDATE = 3'd4
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SPACE   = 2'd1,
        ST_RANGE   = 2'd2,
        ST_DELETED = 2'd3
    } status_t;

    // Sequencer states of the core.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FIND = 2'd1,
        S_PICK = 2'd2,
        S_EXEC = 2'd3
    } state_t;

    // The deleted-slot map is searched in words of this many slots.
    localparam int GROUP_BITS = 16;
    localparam int GROUP_IW   = 4;

    // Controls from the core to the deleted-slot map.
    typedef struct packed {
        logic clear;     // forget every deleted slot
        logic mark;      // flag the addressed slot as deleted
        logic unmark;    // the addressed slot holds a record again
        logic grp_step;  // first search stage: lowest word with a deleted slot
        logic bit_step;  // second search stage: lowest deleted slot in that word
    } map_ctrl_t;

endpackage

>>> src/slotted_page_directory_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Transaction
// in       input      in_valid/in_stall   mode, slot_index, record_size
// out      output     out_valid/out_stall status, record_page, result_slot, byte_offset,
//                                         stored_size, free_bytes, live_records
// cfg      input      cfg_valid/cfg_ready cfg_data (page_number)
//
// An operation passes through accept, group search plus slot-table read, slot search,
// then execute and write back; the single slot-table port and the two-stage deleted-slot
// search set these steps. Reset clears the counters, sets the free pointer to the page end
// and empties the deleted-slot map; the slot table is not cleared, since entries at or above
// the slot count are never used. Results sit in an output register, so a new transaction is
// accepted while an earlier result is stalled; only the execute step waits for it to drain.

module slotted_page_directory_core #(
    parameter int PAGE_BYTES   = 4096,
    parameter int MAX_SLOTS    = 256,
    parameter int HEADER_BYTES = 16,
    parameter int SLOT_BYTES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  slot_index,
    input  logic [12:0] record_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [30:0] record_page,
    output logic [7:0]  result_slot,
    output logic [12:0] byte_offset,
    output logic [12:0] stored_size,
    output logic [12:0] free_bytes,
    output logic [8:0]  live_records,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    // Byte positions within the page, slot addresses and slot counts.
    localparam int PW = $clog2(PAGE_BYTES + 1);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int IW = NW + 8;
    // Wide enough for the free space, the table end and a size plus one slot entry.
    localparam int CW = $clog2(PAGE_BYTES + HEADER_BYTES + MAX_SLOTS * SLOT_BYTES
                               + SLOT_BYTES + 8192) + 1;

    spd_pkg::state_t state_reg, state_next;

    // Page bookkeeping.
    logic [NW-1:0] slots_used_reg, slots_used_next;
    logic [NW-1:0] record_total_reg, record_total_next;
    logic [PW-1:0] free_ptr_reg, free_ptr_next;
    logic [30:0]   page_reg;

    // The operation being worked on.
    logic [2:0]    mode_reg;
    logic [7:0]    slot_idx_reg;
    logic [12:0]   size_reg;

    // Slot table: offset in the upper half, size in the lower half.
    logic [2*PW-1:0] slot_mem [MAX_SLOTS];
    logic [2*PW-1:0] rd_reg;
    logic            mem_re;
    logic            mem_we;
    logic [SW-1:0]   mem_waddr;
    logic [2*PW-1:0] mem_wdata;
    logic [PW-1:0]   rd_off;
    logic [PW-1:0]   rd_size;

    // Output register.
    logic            out_valid_reg;
    logic [1:0]      status_reg;
    logic [7:0]      rslot_reg;
    logic [12:0]     roff_reg;
    logic [12:0]     rsize_reg;
    logic [12:0]     free_reg;
    logic [8:0]      live_reg;

    // Execute-step results.
    spd_pkg::status_t res_status;
    logic [7:0]      res_slot;
    logic [PW-1:0]   res_off;
    logic [PW-1:0]   res_size;
    logic [CW-1:0]   fs_now;
    logic [CW-1:0]   fs_after;
    logic [CW-1:0]   size_c;
    logic [PW-1:0]   new_fp;
    logic            in_range;
    logic            do_mark;
    logic            do_unmark;
    logic            do_clear;

    logic            accept;
    logic            commit;

    spd_pkg::map_ctrl_t map_ctrl;
    logic [SW-1:0]   map_slot;
    logic [SW-1:0]   pick;
    logic            reuse;

    // Bytes between the end of the slot table and the free pointer, floored at zero.
    function automatic logic [CW-1:0] free_space(input logic [PW-1:0] fp,
                                                  input logic [NW-1:0] used);
        logic [CW-1:0] table_end;
        logic [CW-1:0] fp_c;
        table_end = CW'(HEADER_BYTES) + CW'(used) * CW'(SLOT_BYTES);
        fp_c      = CW'(fp);
        return (fp_c >= table_end) ? (fp_c - table_end) : '0;
    endfunction

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    // The execute step finishes once the output register is free or draining.
    assign commit    = (state_reg == spd_pkg::S_EXEC) && (!out_valid_reg || !out_stall);

    assign rd_off  = rd_reg[2*PW-1:PW];
    assign rd_size = rd_reg[PW-1:0];

    spd_free_map #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_free_map (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (map_ctrl),
        .slot (map_slot),
        .pick (pick),
        .reuse(reuse)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = spd_pkg::S_FIND;
                end
            end
            spd_pkg::S_FIND:
            begin
                state_next = spd_pkg::S_PICK;
            end
            spd_pkg::S_PICK:
            begin
                state_next = spd_pkg::S_EXEC;
            end
            spd_pkg::S_EXEC:
            begin
                if (commit)
                begin
                    state_next = spd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spd_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_stall          = 1'b1;
        mem_re            = 1'b0;
        map_ctrl          = '0;
        map_ctrl.clear    = commit && do_clear;
        map_ctrl.mark     = commit && do_mark;
        map_ctrl.unmark   = commit && do_unmark;
        case (state_reg)
            spd_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
            end
            spd_pkg::S_FIND:
            begin
                mem_re            = 1'b1;
                map_ctrl.grp_step = 1'b1;
            end
            spd_pkg::S_PICK:
            begin
                map_ctrl.bit_step = 1'b1;
            end
            spd_pkg::S_EXEC:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Execute step: decide the result and the state update of one operation.
    always_comb
    begin
        fs_now            = free_space(free_ptr_reg, slots_used_reg);
        size_c            = CW'(size_reg);
        new_fp            = free_ptr_reg - PW'(size_reg);
        in_range          = IW'(slot_idx_reg) < IW'(slots_used_reg);
        res_status        = spd_pkg::ST_OK;
        res_slot          = '0;
        res_off           = '0;
        res_size          = '0;
        slots_used_next   = slots_used_reg;
        record_total_next = record_total_reg;
        free_ptr_next     = free_ptr_reg;
        mem_we            = 1'b0;
        mem_waddr         = SW'(slot_idx_reg);
        mem_wdata         = rd_reg;
        map_slot          = SW'(slot_idx_reg);
        do_mark           = 1'b0;
        do_unmark         = 1'b0;
        do_clear          = 1'b0;
        case (mode_reg)
            spd_pkg::MODE_CLEAR:
            begin
                slots_used_next   = '0;
                record_total_next = '0;
                free_ptr_next     = PW'(PAGE_BYTES);
                do_clear          = 1'b1;
            end
            spd_pkg::MODE_INSERT:
            begin
                map_slot = pick;
                if (size_reg == '0)
                begin
                    res_status = spd_pkg::ST_SPACE;
                end
                else if (reuse)
                begin
                    if (size_c > fs_now)
                    begin
                        res_status = spd_pkg::ST_SPACE;
                    end
                end
                else if ((slots_used_reg >= NW'(MAX_SLOTS))
                         || (size_c + CW'(SLOT_BYTES) > fs_now))
                begin
                    res_status = spd_pkg::ST_SPACE;
                end
                if (res_status == spd_pkg::ST_OK)
                begin
                    // A reused slot keeps its place; otherwise the table grows by one.
                    mem_waddr         = reuse ? pick : SW'(slots_used_reg);
                    mem_wdata         = {new_fp, PW'(size_reg)};
                    mem_we            = 1'b1;
                    do_unmark         = reuse;
                    slots_used_next   = reuse ? slots_used_reg : slots_used_reg + NW'(1);
                    free_ptr_next     = new_fp;
                    record_total_next = record_total_reg + NW'(1);
                    res_slot          = reuse ? 8'(pick) : 8'(slots_used_reg);
                    res_off           = new_fp;
                    res_size          = PW'(size_reg);
                end
            end
            spd_pkg::MODE_LOOKUP, spd_pkg::MODE_DELETE, spd_pkg::MODE_UPDATE:
            begin
                res_slot = slot_idx_reg;
                if (!in_range)
                begin
                    res_status = spd_pkg::ST_RANGE;
                end
                else if (rd_size == '0)
                begin
                    res_status = spd_pkg::ST_DELETED;
                end
                else if (mode_reg == spd_pkg::MODE_LOOKUP)
                begin
                    res_off  = rd_off;
                    res_size = rd_size;
                end
                else if (mode_reg == spd_pkg::MODE_DELETE)
                begin
                    mem_wdata         = {rd_off, PW'(0)};
                    mem_we            = 1'b1;
                    do_mark           = 1'b1;
                    record_total_next = record_total_reg - NW'(1);
                    res_off           = rd_off;
                end
                else if (size_reg == '0)
                begin
                    res_status = spd_pkg::ST_SPACE;
                end
                else if (size_c <= CW'(rd_size))
                begin
                    // Shrinking in place: the offset stays.
                    mem_wdata = {rd_off, PW'(size_reg)};
                    mem_we    = 1'b1;
                    res_off   = rd_off;
                    res_size  = PW'(size_reg);
                end
                else if (size_c > fs_now)
                begin
                    // The old record is left untouched.
                    res_status = spd_pkg::ST_SPACE;
                end
                else
                begin
                    mem_wdata     = {new_fp, PW'(size_reg)};
                    mem_we        = 1'b1;
                    free_ptr_next = new_fp;
                    res_off       = new_fp;
                    res_size      = PW'(size_reg);
                end
            end
            default:
            begin
                res_status = spd_pkg::ST_OK;
            end
        endcase
        fs_after = free_space(free_ptr_next, slots_used_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= spd_pkg::S_IDLE;
            slots_used_reg   <= '0;
            record_total_reg <= '0;
            free_ptr_reg     <= PW'(PAGE_BYTES);
            page_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                page_reg <= cfg_data;
            end
            if (commit)
            begin
                slots_used_reg   <= slots_used_next;
                record_total_reg <= record_total_next;
                free_ptr_reg     <= free_ptr_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode;
            slot_idx_reg <= slot_index;
            size_reg     <= record_size;
        end
        if (commit)
        begin
            status_reg <= res_status;
            rslot_reg  <= res_slot;
            roff_reg   <= 13'(res_off);
            rsize_reg  <= 13'(res_size);
            free_reg   <= 13'(fs_after);
            live_reg   <= 9'(record_total_next);
        end
    end

    // Slot table memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (commit && mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= slot_mem[SW'(slot_idx_reg)];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign record_page   = page_reg;
    assign result_slot   = rslot_reg;
    assign byte_offset   = roff_reg;
    assign stored_size   = rsize_reg;
    assign free_bytes    = free_reg;
    assign live_records  = live_reg;

`ifndef SYNTH
    // Every live record occupies a slot of its own.
    assert property (@(posedge clk) disable iff (!rst_n)
        record_total_reg <= slots_used_reg)
        else $error("live record count exceeds slot count");

    // Records never grow into the slot table.
    assert property (@(posedge clk) disable iff (!rst_n)
        CW'(free_ptr_reg) >= CW'(HEADER_BYTES) + CW'(slots_used_reg) * CW'(SLOT_BYTES))
        else $error("free pointer below end of slot table");

    // A result appears only out of the execute step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == spd_pkg::S_EXEC))
        else $error("result loaded outside the execute step");

    // Bookkeeping changes only when an operation completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(slots_used_reg) && $stable(free_ptr_reg))
        else $error("page bookkeeping changed without a completed operation");
`endif

endmodule

>>> src/spd_free_map.sv
`timescale 1ns / 1ps

module spd_free_map #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spd_pkg::map_ctrl_t               ctrl,
    input  logic [$clog2(MAX_SLOTS)-1:0]     slot,
    output logic [$clog2(MAX_SLOTS)-1:0]     pick,
    output logic                             reuse
);

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int NG = (MAX_SLOTS + spd_pkg::GROUP_BITS - 1) / spd_pkg::GROUP_BITS;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;

    // One flag per slot; a set flag is a deleted slot below the slot count.
    logic [spd_pkg::GROUP_BITS-1:0] map_reg [NG];

    logic [NG-1:0]                   grp_any;
    logic [GW-1:0]                   grp_sel;
    logic [GW-1:0]                   grp_reg;
    logic                            grp_hit_reg;
    logic [spd_pkg::GROUP_BITS-1:0]  word;
    logic [spd_pkg::GROUP_IW-1:0]    bit_sel;
    logic [SW-1:0]                   pick_reg;
    logic                            reuse_reg;
    logic [GW-1:0]                   slot_grp;
    logic [spd_pkg::GROUP_IW-1:0]    slot_bit;

    assign slot_grp = GW'(int'(slot) / spd_pkg::GROUP_BITS);
    assign slot_bit = spd_pkg::GROUP_IW'(int'(slot) % spd_pkg::GROUP_BITS);

    always_comb
    begin
        grp_sel = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            grp_any[g] = |map_reg[g];
            if (grp_any[g])
            begin
                grp_sel = GW'(g);
            end
        end
    end

    always_comb
    begin
        word    = map_reg[grp_reg];
        bit_sel = '0;
        for (int b = spd_pkg::GROUP_BITS - 1; b >= 0; b--)
        begin
            if (word[b])
            begin
                bit_sel = spd_pkg::GROUP_IW'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NG; g++)
            begin
                map_reg[g] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int g = 0; g < NG; g++)
            begin
                map_reg[g] <= '0;
            end
        end
        else if (ctrl.mark)
        begin
            map_reg[slot_grp][slot_bit] <= 1'b1;
        end
        else if (ctrl.unmark)
        begin
            map_reg[slot_grp][slot_bit] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.grp_step)
        begin
            grp_reg     <= grp_sel;
            grp_hit_reg <= |grp_any;
        end
        if (ctrl.bit_step)
        begin
            pick_reg  <= SW'(int'(grp_reg) * spd_pkg::GROUP_BITS + int'(bit_sel));
            reuse_reg <= grp_hit_reg;
        end
    end

    assign pick  = pick_reg;
    assign reuse = reuse_reg;

endmodule

>>> tb/slotted_page_directory_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the slot directory core. Input transactions come from a directed
// table first, then from five random phases, each under its own page number and traffic
// profile. Every accepted input transaction is run through a bench-side copy of the
// directory bookkeeping. The resulting expectation is queued and compared field by field
// with the next result transaction that leaves the core.
module slotted_page_directory_core_tb;
    import spd_pkg::*;

    localparam int PAGE_BYTES   = 4096;
    localparam int MAX_SLOTS    = 256;
    localparam int HEADER_BYTES = 16;
    localparam int SLOT_BYTES   = 8;

    localparam int CYCLE_LIMIT  = 400000;
    // Idle cycles after the last result.
    localparam int DRAIN_CYCLES = 8;

    // Mode value outside the package enum; the core must answer it without side effects.
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef enum int {
        PROF_TINY,
        PROF_MEDIUM,
        PROF_LARGE,
        PROF_UPDATE,
        PROF_MIXED
    } profile_t;

    // One result transaction, laid out like the output ports from status to live_records.
    typedef struct packed {
        status_t     status;
        logic [30:0] page;
        logic [7:0]  slot;
        logic [12:0] offset;
        logic [12:0] size;
        logic [12:0] free;
        logic [8:0]  live;
    } dir_result_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  idx;
        logic [12:0] len;
        logic        typed;
        dir_result_t want;
    } directed_row_t;

    localparam dir_result_t NO_WANT = '0;

    // Directed table. Rows with typed set carry the result as it reads straight off the
    // behavior; the other rows are checked against the bench's bookkeeping.
    localparam directed_row_t DIRECTED [25] = '{
        // Empty page: nothing is addressable yet, and a zero-length insert is refused.
        '{MODE_LOOKUP, 8'd0, 13'd0, 1'b1, '{ST_RANGE, 31'd0, 8'd0, 13'd0, 13'd0, 13'd4080, 9'd0}},
        '{MODE_INSERT, 8'd0, 13'd0, 1'b1, '{ST_SPACE, 31'd0, 8'd0, 13'd0, 13'd0, 13'd4080, 9'd0}},
        '{MODE_INSERT, 8'd0, 13'd100, 1'b1,
          '{ST_OK, 31'd0, 8'd0, 13'd3996, 13'd100, 13'd3972, 9'd1}},
        // Oversized records, including the full field width.
        '{MODE_INSERT, 8'd0, 13'd8191, 1'b1,
          '{ST_SPACE, 31'd0, 8'd0, 13'd0, 13'd0, 13'd3972, 9'd1}},
        '{MODE_INSERT, 8'd0, 13'd4096, 1'b1,
          '{ST_SPACE, 31'd0, 8'd0, 13'd0, 13'd0, 13'd3972, 9'd1}},
        '{MODE_INSERT, 8'd0, 13'd1, 1'b1, '{ST_OK, 31'd0, 8'd1, 13'd3995, 13'd1, 13'd3963, 9'd2}},
        '{MODE_LOOKUP, 8'd0, 13'd0, 1'b1,
          '{ST_OK, 31'd0, 8'd0, 13'd3996, 13'd100, 13'd3963, 9'd2}},
        '{MODE_LOOKUP, 8'd255, 13'd0, 1'b1,
          '{ST_RANGE, 31'd0, 8'd255, 13'd0, 13'd0, 13'd3963, 9'd2}},
        // Delete reports the old offset; the next accesses to the slot see it deleted.
        '{MODE_DELETE, 8'd0, 13'd0, 1'b1, '{ST_OK, 31'd0, 8'd0, 13'd3996, 13'd0, 13'd3963, 9'd1}},
        '{MODE_LOOKUP, 8'd0, 13'd0, 1'b1,
          '{ST_DELETED, 31'd0, 8'd0, 13'd0, 13'd0, 13'd3963, 9'd1}},
        '{MODE_DELETE, 8'd0, 13'd0, 1'b1,
          '{ST_DELETED, 31'd0, 8'd0, 13'd0, 13'd0, 13'd3963, 9'd1}},
        '{MODE_UPDATE, 8'd0, 13'd5, 1'b1,
          '{ST_DELETED, 31'd0, 8'd0, 13'd0, 13'd0, 13'd3963, 9'd1}},
        // The lowest deleted slot is reused before a new one is appended.
        '{MODE_INSERT, 8'd0, 13'd50, 1'b1,
          '{ST_OK, 31'd0, 8'd0, 13'd3945, 13'd50, 13'd3913, 9'd2}},
        '{MODE_UPDATE, 8'd0, 13'd0, 1'b1,
          '{ST_SPACE, 31'd0, 8'd0, 13'd0, 13'd0, 13'd3913, 9'd2}},
        '{MODE_UPDATE, 8'd0, 13'd20, 1'b1,
          '{ST_OK, 31'd0, 8'd0, 13'd3945, 13'd20, 13'd3913, 9'd2}},
        // Same size again, then a grow that relocates, then a grow that cannot fit.
        '{MODE_UPDATE, 8'd0, 13'd20, 1'b0, NO_WANT},
        '{MODE_UPDATE, 8'd1, 13'd200, 1'b0, NO_WANT},
        '{MODE_UPDATE, 8'd1, 13'd8191, 1'b0, NO_WANT},
        '{MODE_LOOKUP, 8'd1, 13'd0, 1'b0, NO_WANT},
        // First slot past the end of the table.
        '{MODE_DELETE, 8'd2, 13'd0, 1'b0, NO_WANT},
        '{MODE_SPARE_7, 8'd255, 13'd8191, 1'b0, NO_WANT},
        '{MODE_CLEAR, 8'd0, 13'd0, 1'b1, '{ST_OK, 31'd0, 8'd0, 13'd0, 13'd0, 13'd4080, 9'd0}},
        // A record that uses every free byte, then no room for anything more.
        '{MODE_INSERT, 8'd0, 13'd4072, 1'b0, NO_WANT},
        '{MODE_INSERT, 8'd0, 13'd1, 1'b0, NO_WANT},
        '{MODE_UPDATE, 8'd0, 13'd4073, 1'b0, NO_WANT}
    };

    localparam profile_t PHASE_PROFILE [5] = '{
        PROF_TINY, PROF_MEDIUM, PROF_LARGE, PROF_UPDATE, PROF_MIXED
    };
    // The tiny phase is long enough to run the directory up to its full slot count.
    localparam int PHASE_ITEMS [5] = '{400, 250, 200, 200, 200};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = '0;
    logic [7:0]  slot_index = '0;
    logic [12:0] record_size = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [30:0] record_page;
    logic [7:0]  result_slot;
    logic [12:0] byte_offset;
    logic [12:0] stored_size;
    logic [12:0] free_bytes;
    logic [8:0]  live_records;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data = '0;

    // Bench-side copy of the directory state and of the page number register.
    int          slot_off [MAX_SLOTS];
    int          slot_len [MAX_SLOTS];
    int          n_slots = 0;
    int          n_live = 0;
    int          free_ptr = PAGE_BYTES;
    logic [30:0] page_reg = '0;

    dir_result_t pending_results [$];
    dir_result_t head_result;

    int          cycle_count = 0;
    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          page_settings = 0;
    int          peak_slots = 0;
    int          peak_live = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    int          burst_left = 0;
    int          stall_style = 0;
    int          stall_hold = 0;

    slotted_page_directory_core #(
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_SLOTS   (MAX_SLOTS),
        .HEADER_BYTES(HEADER_BYTES),
        .SLOT_BYTES  (SLOT_BYTES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .slot_index   (slot_index),
        .record_size  (record_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .record_page  (record_page),
        .result_slot  (result_slot),
        .byte_offset  (byte_offset),
        .stored_size  (stored_size),
        .free_bytes   (free_bytes),
        .live_records (live_records),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Bytes between the end of the slot table and the lowest record.
    function automatic int page_room();
        int table_end;
        table_end = HEADER_BYTES + n_slots * SLOT_BYTES;
        return (free_ptr >= table_end) ? free_ptr - table_end : 0;
    endfunction

    // Applies one operation to the bench copy of the directory and returns its result.
    function automatic dir_result_t directory_op_result(input logic [2:0] op,
                                                        input logic [7:0] idx,
                                                        input logic [12:0] len);
        dir_result_t r;
        int          sz;
        int          slot;
        int          pick;
        bit          reuse;
        sz = len;
        slot = idx;
        pick = n_slots;
        reuse = 1'b0;
        r = '0;
        r.status = ST_OK;
        r.page = page_reg;
        case (op)
            MODE_CLEAR:
            begin
                n_slots = 0;
                n_live = 0;
                free_ptr = PAGE_BYTES;
            end
            MODE_INSERT:
            begin
                for (int i = 0; i < n_slots; i++)
                begin
                    if (!reuse && slot_len[i] == 0)
                    begin
                        pick = i;
                        reuse = 1'b1;
                    end
                end
                // A reused slot only needs the record bytes; a new one also needs its entry.
                if (sz == 0)
                    r.status = ST_SPACE;
                else if (reuse)
                begin
                    if (sz > page_room())
                        r.status = ST_SPACE;
                end
                else if (n_slots >= MAX_SLOTS || sz + SLOT_BYTES > page_room())
                    r.status = ST_SPACE;
                if (r.status == ST_OK)
                begin
                    if (!reuse)
                        n_slots++;
                    free_ptr -= sz;
                    slot_off[pick] = free_ptr;
                    slot_len[pick] = sz;
                    n_live++;
                    r.slot = 8'(pick);
                    r.offset = 13'(free_ptr);
                    r.size = 13'(sz);
                end
            end
            MODE_LOOKUP, MODE_DELETE, MODE_UPDATE:
            begin
                r.slot = idx;
                if (slot >= n_slots)
                    r.status = ST_RANGE;
                else if (slot_len[slot] == 0)
                    r.status = ST_DELETED;
                else if (op == MODE_LOOKUP)
                begin
                    r.offset = 13'(slot_off[slot]);
                    r.size = 13'(slot_len[slot]);
                end
                else if (op == MODE_DELETE)
                begin
                    r.offset = 13'(slot_off[slot]);
                    slot_len[slot] = 0;
                    n_live--;
                end
                else
                begin
                    // Shrinking stays in place; growing moves the record below the free
                    // pointer, and a failed grow leaves the old record untouched.
                    if (sz == 0)
                        r.status = ST_SPACE;
                    else if (sz <= slot_len[slot])
                        slot_len[slot] = sz;
                    else if (sz > page_room())
                        r.status = ST_SPACE;
                    else
                    begin
                        free_ptr -= sz;
                        slot_off[slot] = free_ptr;
                        slot_len[slot] = sz;
                    end
                    if (r.status == ST_OK)
                    begin
                        r.offset = 13'(slot_off[slot]);
                        r.size = 13'(slot_len[slot]);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.free = 13'(page_room());
        r.live = 9'(n_live);
        return r;
    endfunction

    // Draws one random input transaction. Most of them address slots in the table and use
    // sizes that fit the profile, so the directory fills, fragments and runs out of room.
    task automatic draw_item(input profile_t prof, output logic [2:0] op,
                             output logic [7:0] idx, output logic [12:0] len);
        int w_clear;
        int w_ins;
        int w_look;
        int w_del;
        int roll;
        int room;
        case (prof)
            PROF_TINY:
            begin
                w_clear = 0;
                w_ins = 80;
                w_look = 86;
                w_del = 90;
            end
            PROF_MEDIUM:
            begin
                w_clear = 2;
                w_ins = 42;
                w_look = 62;
                w_del = 80;
            end
            PROF_LARGE:
            begin
                w_clear = 4;
                w_ins = 48;
                w_look = 58;
                w_del = 73;
            end
            PROF_UPDATE:
            begin
                w_clear = 2;
                w_ins = 27;
                w_look = 37;
                w_del = 50;
            end
            default:
            begin
                w_clear = 2;
                w_ins = 37;
                w_look = 57;
                w_del = 75;
            end
        endcase
        roll = $urandom_range(0, 99);
        room = page_room();

        if (n_slots > 0 && $urandom_range(0, 9) != 0)
            idx = 8'($urandom_range(0, n_slots - 1));
        else if ($urandom_range(0, 1) == 0 && n_slots < MAX_SLOTS)
            idx = 8'(n_slots);
        else
            idx = 8'($urandom_range(0, 255));

        case (prof)
            PROF_TINY:
                len = 13'($urandom_range(1, 8));
            PROF_MEDIUM:
                len = 13'($urandom_range(1, 400));
            PROF_LARGE:
            begin
                // Aim at the boundary of the remaining space from both sides.
                case ($urandom_range(0, 3))
                    0: len = 13'($urandom_range(1, room + 16));
                    1: len = 13'(room);
                    2: len = 13'((room > SLOT_BYTES) ? room - SLOT_BYTES : 1);
                    default: len = 13'($urandom_range(0, 8191));
                endcase
            end
            PROF_UPDATE:
            begin
                if (idx < n_slots && slot_len[idx] > 0)
                begin
                    case ($urandom_range(0, 3))
                        0: len = 13'((slot_len[idx] > 1) ? slot_len[idx] - 1 : 1);
                        1: len = 13'(slot_len[idx]);
                        2: len = 13'(slot_len[idx] + 1);
                        default: len = 13'($urandom_range(1, room + slot_len[idx] + 8));
                    endcase
                end
                else
                    len = 13'($urandom_range(1, 300));
            end
            default:
                len = 13'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 4100 : 200));
        endcase
        if ($urandom_range(0, 32) == 0)
            len = '0;

        if (roll < w_clear)
            op = MODE_CLEAR;
        else if (roll < w_ins)
            op = MODE_INSERT;
        else if (roll < w_look)
            op = MODE_LOOKUP;
        else if (roll < w_del)
            op = MODE_DELETE;
        else if (roll < 94)
            op = MODE_UPDATE;
        else
        begin
            // Noise: any mode but clear, with unconstrained fields.
            op = 3'($urandom_range(1, 7));
            idx = 8'($urandom);
            len = 13'($urandom);
        end
    endtask

    // Offers one input transaction, holding it until accepted, and queues its expectation.
    // The sender runs in bursts; between bursts it may drop valid for a random gap.
    task automatic push_transaction(input logic [2:0] op, input logic [7:0] idx,
                                    input logic [12:0] len, input logic typed,
                                    input dir_result_t want);
        dir_result_t predicted;
        int          gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        mode <= op;
        slot_index <= idx;
        record_size <= len;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);

        predicted = directory_op_result(op, idx, len);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        status_seen[predicted.status]++;
        if (n_slots > peak_slots)
            peak_slots = n_slots;
        if (n_live > peak_live)
            peak_live = n_live;
    endtask

    // Lets every queued result come out before the configuration changes.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_page_number(input logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        page_reg = value;
        page_settings++;
    endtask

    // Main stimulus: reset, the directed table under the reset page number, then the
    // random phases, each opened by a page number write and a clear.
    initial
    begin
        logic [2:0]  op;
        logic [7:0]  idx;
        logic [12:0] len;
        logic [30:0] pg;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
            push_transaction(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].len,
                             DIRECTED[i].typed, DIRECTED[i].want);
        wait_for_idle();

        for (int p = 0; p < $size(PHASE_ITEMS); p++)
        begin
            case (p)
                0: pg = 31'h7FFF_FFFF;
                1: pg = '0;
                4: pg = 31'h2AAA_AAAA;
                default: pg = 31'($urandom);
            endcase
            write_page_number(pg);
            push_transaction(MODE_CLEAR, '0, '0, 1'b0, NO_WANT);
            for (int k = 1; k < PHASE_ITEMS[p]; k++)
            begin
                draw_item(PHASE_PROFILE[p], op, idx, len);
                push_transaction(op, idx, len, 1'b0, NO_WANT);
            end
            wait_for_idle();
        end

        $display("%0d input transactions, %0d results checked, %0d page numbers written",
                 items_sent, results_checked, page_settings);
        $display("peak %0d slots / %0d live records; ok %0d, space %0d, range %0d, deleted %0d",
                 peak_slots, peak_live, status_seen[ST_OK], status_seen[ST_SPACE],
                 status_seen[ST_RANGE], status_seen[ST_DELETED]);
        if (error_count == 0)
            $display("slotted_page_directory_core_tb passed");
        else
            $display("slotted_page_directory_core_tb failed");
        $finish;
    end

    // The receiver switches between stall patterns at random times: never,
    // sparse, heavy and a fixed rhythm.
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_hold <= $urandom_range(20, 200);
        end
        else
            stall_hold <= stall_hold - 1;
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((cycle_count % 5) < 2);
        endcase
    end

    // Each accepted result transaction is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result transaction: status %0d slot %0d offset %0d",
                             status, result_slot, byte_offset);
            end
            else
            begin
                head_result = pending_results.pop_front();
                results_checked++;
                if ({status, record_page, result_slot, byte_offset, stored_size, free_bytes,
                     live_records} !== head_result)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("mismatch on result %0d", results_checked);
                        $display("  expected status %0d page %h slot %0d off %0d size %0d free %0d live %0d",
                                 head_result.status, head_result.page, head_result.slot,
                                 head_result.offset, head_result.size, head_result.free,
                                 head_result.live);
                        $display("  actual   status %0d page %h slot %0d off %0d size %0d free %0d live %0d",
                                 status, record_page, result_slot, byte_offset, stored_size,
                                 free_bytes, live_records);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("slotted_page_directory_core_tb failed");
            $finish;
        end
    end

endmodule

>>> sim.f
src/spd_pkg.sv
src/spd_free_map.sv
src/slotted_page_directory_core.sv
tb/slotted_page_directory_core_tb.sv
